@@ rtl/speed_pi_lowpass_loop_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Speed loop assertion macros
// Shared property wrappers for the speed loop checks.
// ----------------------------------------------------------------------------
`ifndef SPEED_PI_LOWPASS_LOOP_UNIT_ASSERT_SVH
`define SPEED_PI_LOWPASS_LOOP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SPLL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("speed loop assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SPLL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("speed loop assertion failed");

`endif

@@ rtl/spll_pkg.sv @@
// ----------------------------------------------------------------------------
// Speed loop package
// Widths, sequencer states, register indexes and multiplier control type.
// ----------------------------------------------------------------------------
`default_nettype none

package spll_pkg;

  localparam int SPD_W   = 16;
  localparam int ERR_W   = 25;
  localparam int OPA_W   = 17;
  localparam int PROD_W  = OPA_W + ERR_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int ALPHA_W = 9;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_SETPOINT  = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROP_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_LIM = 3'd3;
  localparam logic [IDX_W-1:0] REG_ALPHA     = 3'd4;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd179;
  localparam logic [SPD_W-1:0]   LIMIT_RESET = 16'd10000;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_A = 7'b0000010,
    ST_MUL_B = 7'b0000100,
    ST_FILT  = 7'b0001000,
    ST_MUL_P = 7'b0010000,
    ST_MUL_I = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/spll_mac.sv @@
// ----------------------------------------------------------------------------
// Speed loop multiply-accumulate unit
// One signed multiplier feeding a registered accumulator, shared by all multiply steps.
// ----------------------------------------------------------------------------
`default_nettype none

module spll_mac (
  input  wire logic                                clk,
  input  wire spll_pkg::mac_ctrl_t                 ctrl,
  input  wire logic signed [spll_pkg::OPA_W-1:0]   op_a,
  input  wire logic signed [spll_pkg::ERR_W-1:0]   op_b,
  output logic signed [spll_pkg::ACC_W-1:0]        acc
);

  logic signed [spll_pkg::PROD_W-1:0] prod;
  logic signed [spll_pkg::ACC_W-1:0]  acc_next;

  always_comb begin
    prod     = op_a * op_b;
    acc_next = (ctrl.clear ? '0 : acc) + {prod[spll_pkg::PROD_W-1], prod};
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/speed_pi_lowpass_loop_unit.sv @@
// ----------------------------------------------------------------------------
// Speed PI loop with low-pass error filter and clamped integral
// An input transfer runs MUL_A, MUL_B, FILT, MUL_P, MUL_I and DONE in order,
// with four multiplier passes; DONE can stall, and s_tready is high only in IDLE.
// Reset (rst, synchronous): registers to defaults, filter and integral to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_pi_lowpass_loop_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // speed_left[15:0], speed_right[31:16]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // drive[31:0]
  output logic             m_tuser,   // integral_clamped[0]
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

`include "speed_pi_lowpass_loop_unit_assert.svh"

  spll_pkg::state_t state, state_next;

  logic signed [15:0] speed_setpoint;
  logic signed [15:0] prop_gain;
  logic signed [15:0] integ_gain;
  logic        [15:0] integral_limit;
  logic        [8:0]  filter_alpha;

  logic signed [spll_pkg::ERR_W-1:0] err;
  logic signed [spll_pkg::ERR_W-1:0] filtered_error;
  logic signed [spll_pkg::ERR_W-1:0] error_integral;
  logic                              clamped;

  logic signed [16:0]                lr_sum;
  logic signed [25:0]                err_calc;
  logic        [8:0]                 alpha_sat;
  logic        [8:0]                 alpha_cmp;
  logic signed [spll_pkg::ERR_W-1:0] filt_new;
  logic signed [25:0]                integ_sum;
  logic signed [25:0]                lim_pos;
  logic signed [25:0]                lim_neg;
  logic signed [spll_pkg::ERR_W-1:0] integ_next;
  logic                              clamp_next;
  logic                              load_out;

  spll_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [spll_pkg::OPA_W-1:0]  mac_a;
  logic signed [spll_pkg::ERR_W-1:0]  mac_b;
  logic signed [spll_pkg::ACC_W-1:0]  acc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == spll_pkg::ST_IDLE);
  assign load_out  = (state == spll_pkg::ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    lr_sum    = {s_tdata[15], s_tdata[15:0]} + {s_tdata[31], s_tdata[31:16]};
    err_calc  = {{2{speed_setpoint[15]}}, speed_setpoint, 8'b0}
              - {{2{lr_sum[16]}}, lr_sum, 7'b0};
    alpha_sat = (filter_alpha > spll_pkg::ALPHA_ONE) ? spll_pkg::ALPHA_ONE : filter_alpha;
    alpha_cmp = spll_pkg::ALPHA_ONE - alpha_sat;
    filt_new  = acc[32:8];
    integ_sum = {error_integral[spll_pkg::ERR_W-1], error_integral}
              + {filt_new[spll_pkg::ERR_W-1], filt_new};
    lim_pos   = {2'b00, integral_limit, 8'b0};
    lim_neg   = -lim_pos;
    if (integ_sum > lim_pos) begin
      integ_next = lim_pos[spll_pkg::ERR_W-1:0];
      clamp_next = 1'b1;
    end else if (integ_sum < lim_neg) begin
      integ_next = lim_neg[spll_pkg::ERR_W-1:0];
      clamp_next = 1'b1;
    end else begin
      integ_next = integ_sum[spll_pkg::ERR_W-1:0];
      clamp_next = 1'b0;
    end
  end

  always_comb begin
    state_next     = state;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.en    = 1'b0;
    mac_a          = '0;
    mac_b          = '0;
    case (state)
      spll_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = spll_pkg::ST_MUL_A;
        end
      end
      spll_pkg::ST_MUL_A: begin
        mac_ctrl.clear = 1'b1;
        mac_ctrl.en    = 1'b1;
        mac_a          = {8'b0, alpha_sat};
        mac_b          = err;
        state_next     = spll_pkg::ST_MUL_B;
      end
      spll_pkg::ST_MUL_B: begin
        mac_ctrl.en = 1'b1;
        mac_a       = {8'b0, alpha_cmp};
        mac_b       = filtered_error;
        state_next  = spll_pkg::ST_FILT;
      end
      spll_pkg::ST_FILT: begin
        state_next = spll_pkg::ST_MUL_P;
      end
      spll_pkg::ST_MUL_P: begin
        mac_ctrl.clear = 1'b1;
        mac_ctrl.en    = 1'b1;
        mac_a          = {prop_gain[15], prop_gain};
        mac_b          = filtered_error;
        state_next     = spll_pkg::ST_MUL_I;
      end
      spll_pkg::ST_MUL_I: begin
        mac_ctrl.en = 1'b1;
        mac_a       = {integ_gain[15], integ_gain};
        mac_b       = error_integral;
        state_next  = spll_pkg::ST_DONE;
      end
      spll_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = spll_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spll_pkg::ST_IDLE;
      end
    endcase
  end

  spll_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= spll_pkg::ST_IDLE;
      speed_setpoint <= '0;
      prop_gain      <= '0;
      integ_gain     <= '0;
      integral_limit <= spll_pkg::LIMIT_RESET;
      filter_alpha   <= spll_pkg::ALPHA_RESET;
      filtered_error <= '0;
      error_integral <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          spll_pkg::REG_SETPOINT:   speed_setpoint <= cfg_data;
          spll_pkg::REG_PROP_GAIN:  prop_gain      <= cfg_data;
          spll_pkg::REG_INTEG_GAIN: integ_gain     <= cfg_data;
          spll_pkg::REG_INTEG_LIM:  integral_limit <= cfg_data;
          spll_pkg::REG_ALPHA:      filter_alpha   <= cfg_data[8:0];
          default: begin
          end
        endcase
      end
      if (state == spll_pkg::ST_FILT) begin
        filtered_error <= filt_new;
        error_integral <= integ_next;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // The drive sum stays far inside 32 bits, so the floor shift never saturates.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      err <= err_calc[spll_pkg::ERR_W-1:0];
    end
    if (state == spll_pkg::ST_FILT) begin
      clamped <= clamp_next;
    end
    if (load_out) begin
      m_tdata <= {{5{acc[spll_pkg::ACC_W-1]}}, acc[spll_pkg::ACC_W-1:16]};
      m_tuser <= clamped;
    end
  end

  `SPLL_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready,
                    state == spll_pkg::ST_MUL_A && !s_tready)
  `SPLL_ASSERT_NEXT(a_done_loads_out, clk, rst, load_out, m_tvalid)
  `SPLL_ASSERT_NEXT(a_clamp_at_limit, clk, rst,
                    state == spll_pkg::ST_FILT && clamp_next,
                    error_integral == $past(lim_pos[spll_pkg::ERR_W-1:0]) ||
                    error_integral == $past(lim_neg[spll_pkg::ERR_W-1:0]))

endmodule

`default_nettype wire
